### rtl/core/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue.
// Word structs for both channels, entry and cell control types.
// No dependencies.
package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] item_value;
    logic        [15:0] item_priority;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic        [15:0] removed_priority;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [15:0] prio;
  } entry_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic ins;       // insert taken this cycle (queue not full)
    logic rem;       // remove taken this cycle (queue not empty)
    logic occupied;  // cell index below the fill count
    logic at_tail;   // cell index equals the fill count
  } cell_ctrl_t;

endpackage

### rtl/core/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue held as a row of sorted cells.
// Instantiates spq_cell CAPACITY times; depends on spq_pkg.
//
// Entries sit in a row of CAPACITY cells, head in cell 0, kept in ascending
// priority number; equal priorities stay in arrival order. Each input word is
// an insert or a remove and produces exactly one result word. An insert is
// broadcast to all cells, every occupied cell with a larger priority number
// hands its entry one cell back and the new entry drops into the gap, all
// at the same clock edge. A remove returns the head and every cell takes its
// right neighbor's entry. So the queue takes one word per cycle while
// in_stall_o is low; the cell row compares and shifts as the word is
// accepted. Results go to an output register
// backed by a skid register, so a word is still accepted while one result
// waits; in_stall_o rises only when both hold a result. Remove on an empty
// queue returns status ST_EMPTY, insert on a full queue returns ST_FULL and
// drops the entry; value and priority read zero in both cases and on every
// insert. Cell contents need no reset: only cells below the fill count are
// read, and there is no clearing pass after reset.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_word_t out_word_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;

  logic accept, is_full, is_empty, do_ins, do_rem;

  spq_pkg::entry_t    new_entry;
  spq_pkg::entry_t    cell_data [CAPACITY];
  logic               cell_disp [CAPACITY];
  spq_pkg::out_word_t result;

  // output register plus skid register
  logic               out_valid_q, skid_valid_q;
  spq_pkg::out_word_t out_word_q, skid_word_q;
  logic               out_fire;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign do_ins   = accept && (in_word_i.operation == spq_pkg::OP_INSERT) && !is_full;
  assign do_rem   = accept && (in_word_i.operation == spq_pkg::OP_REMOVE) && !is_empty;

  assign new_entry.value = in_word_i.item_value;
  assign new_entry.prio  = in_word_i.item_priority;

  // ---- cell row ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::cell_ctrl_t ctrl;
    logic                left_disp;
    spq_pkg::entry_t     left_data, right_data;

    assign ctrl.ins      = do_ins;
    assign ctrl.rem      = do_rem;
    assign ctrl.occupied = (CntW'(i) < count_q);
    assign ctrl.at_tail  = (CntW'(i) == count_q);

    if (i == 0) begin : g_head
      assign left_disp = 1'b0;
      assign left_data = '0;
    end else begin : g_mid
      assign left_disp = cell_disp[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .left_disp_i (left_disp),
      .left_i      (left_data),
      .right_i     (right_data),
      .disp_o      (cell_disp[i]),
      .data_o      (cell_data[i])
    );
  end

  // ---- fill count ----
  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // ---- result word ----
  always_comb begin
    result = '0;
    result.status = spq_pkg::ST_DONE;
    if (in_word_i.operation == spq_pkg::OP_REMOVE) begin
      if (is_empty) begin
        result.status = spq_pkg::ST_EMPTY;
      end else begin
        result.removed_value    = cell_data[0].value;
        result.removed_priority = cell_data[0].prio;
      end
    end else if (is_full) begin
      result.status = spq_pkg::ST_FULL;
    end
  end

  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_word_q <= result;
      end else begin
        skid_word_q <= result;
      end
    end else if (out_fire && skid_valid_q) begin
      out_word_q <= skid_word_q;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a word while output register is empty");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rem |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove did not shrink the queue by one");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_data[0].prio <= cell_data[1].prio))
    else $error("head cells out of priority order");
`endif

endmodule

### rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted queue row.
// Compares the broadcast entry, shifts from left on insert, from right on remove.
// Depends on spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     new_i,
  input  logic                left_disp_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output logic                disp_o,
  output spq_pkg::entry_t     data_o
);

  spq_pkg::entry_t data_q;

  // displaced: the new entry belongs ahead of this one
  assign disp_o = ctrl_i.occupied && (data_q.prio > new_i.prio);
  assign data_o = data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && (disp_o || ctrl_i.at_tail)) begin
      data_q <= left_disp_i ? left_i : new_i;
    end else if (ctrl_i.rem) begin
      data_q <= right_i;
    end
  end

endmodule
